/* rtl/cov_pkg.sv */
// shared types, constants and width helpers of the covariance matrix block
package cov_pkg;

  localparam int MAX_VARS_DEF    = 8;
  localparam int MAX_OBS_DEF     = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int IDX_W         = 3;
  localparam int OBS_IN_W      = 8;
  localparam int SAMPLE_W      = 16;
  localparam int COV_W         = 40;
  localparam int FRAC_BITS     = 8;
  localparam int NUM_VARS_W    = 4;
  localparam int NUM_SAMPLES_W = 9;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;
  localparam int CMD_DEPTH     = 2;
  localparam int OUT_DEPTH     = 2;

  localparam logic REG_NUM_VARS    = 1'b0;
  localparam logic REG_NUM_SAMPLES = 1'b1;

  typedef struct packed {
    logic wr;
    logic calc;
  } cmd_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DRAIN,
    S_MUL1,
    S_MUL2,
    S_PREP,
    S_DIV,
    S_EMIT
  } back_state_e;

  function automatic int var_w(int max_vars);
    return (max_vars > 1) ? $clog2(max_vars) : 1;
  endfunction

  function automatic int obs_w(int max_obs);
    return $clog2(max_obs);
  endfunction

  function automatic int cnt_w(int max_obs);
    return $clog2(max_obs + 1);
  endfunction

endpackage

/* rtl/cov_ram.sv */
// generic ram, one write port and two registered read ports
module cov_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* rtl/cov_fifo.sv */
// small first-in first-out queue with registered storage
module cov_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/cov_front.sv */
// front end: accepts sample beats, classifies them and queues commands
module cov_front import cov_pkg::*; #(
  parameter int MAX_VARS    = MAX_VARS_DEF,
  parameter int MAX_OBS     = MAX_OBS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [IDX_W-1:0]     var_index_i,
  input  logic [OBS_IN_W-1:0]  obs_index_i,
  input  logic [SAMPLE_W-1:0]  sample_value_i,
  input  logic                 load_done_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output cmd_ctrl_t            cmd_ctrl_o,
  output logic [var_w(MAX_VARS)+obs_w(MAX_OBS)-1:0] cmd_addr_o,
  output logic [SAMPLE_BITS-1:0] cmd_data_o
);

  localparam int VW    = var_w(MAX_VARS);
  localparam int OBS_W = obs_w(MAX_OBS);
  localparam int AW    = VW + OBS_W;
  localparam int CPY   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int QW    = $bits(cmd_ctrl_t) + AW + SAMPLE_BITS;

  cmd_ctrl_t              ctrl;
  logic [AW-1:0]          addr;
  logic [SAMPLE_BITS-1:0] val;
  logic [QW-1:0]          q_out;
  logic                   q_empty;

  always_comb begin
    ctrl.wr   = (int'(var_index_i) < MAX_VARS) && (int'(obs_index_i) < MAX_OBS);
    ctrl.calc = load_done_i;
    addr      = {var_index_i[VW-1:0], OBS_W'(obs_index_i)};
    val       = '0;
    val[CPY-1:0] = sample_value_i[CPY-1:0];
  end

  cov_fifo #(
    .WIDTH (QW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({ctrl, addr, val}),
    .full_o  (full),
    .pop_i   (cmd_ready_i),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign cmd_valid_o = !q_empty;
  assign {cmd_ctrl_o, cmd_addr_o, cmd_data_o} = q_out;

endmodule

/* rtl/cov_back.sv */
// back end: stores samples and computes each covariance entry in turn
module cov_back import cov_pkg::*; #(
  parameter int MAX_VARS    = MAX_VARS_DEF,
  parameter int MAX_OBS     = MAX_OBS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  cmd_ctrl_t                 cmd_ctrl_i,
  input  logic [var_w(MAX_VARS)+obs_w(MAX_OBS)-1:0] cmd_addr_i,
  input  logic [SAMPLE_BITS-1:0]    cmd_data_i,
  input  logic [NUM_VARS_W-1:0]     num_vars_i,
  input  logic [NUM_SAMPLES_W-1:0]  num_samples_i,
  output logic                      ram_we_o,
  output logic [var_w(MAX_VARS)+obs_w(MAX_OBS)-1:0] ram_waddr_o,
  output logic [SAMPLE_BITS-1:0]    ram_wdata_o,
  output logic [var_w(MAX_VARS)+obs_w(MAX_OBS)-1:0] ram_raddr_a_o,
  output logic [var_w(MAX_VARS)+obs_w(MAX_OBS)-1:0] ram_raddr_b_o,
  input  logic [SAMPLE_BITS-1:0]    ram_rdata_a_i,
  input  logic [SAMPLE_BITS-1:0]    ram_rdata_b_i,
  output logic                      out_push_o,
  input  logic                      out_full_i,
  output logic [IDX_W-1:0]          out_row_o,
  output logic [IDX_W-1:0]          out_col_o,
  output logic [COV_W-1:0]          out_cov_o,
  output logic                      out_final_o
);

  localparam int SB     = SAMPLE_BITS;
  localparam int VW     = var_w(MAX_VARS);
  localparam int OBS_W  = obs_w(MAX_OBS);
  localparam int LOGN   = cnt_w(MAX_OBS);
  localparam int D_W    = 2 * LOGN;
  localparam int PR_W   = 2 * SB;
  localparam int SX_W   = SB + LOGN;
  localparam int SXY_W  = 2 * SB + LOGN;
  localparam int MAG_W  = 2 * SB + 2 * LOGN;
  localparam int NUM_W  = MAG_W + 1;
  localparam int DVD_W  = MAG_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(DVD_W);
  localparam int EXW    = (DVD_W > COV_W) ? DVD_W + 1 : COV_W + 1;
  localparam int CMPW   = (LOGN > NUM_SAMPLES_W) ? LOGN : NUM_SAMPLES_W;

  back_state_e state_q, state_d;

  logic [NUM_VARS_W-1:0] m_q, m_clamp;
  logic [LOGN-1:0]       n_q, n_clamp;
  logic [D_W-1:0]        d_q;
  logic [IDX_W-1:0]      i_q, j_q;
  logic [OBS_W-1:0]      k_q;
  logic                  v1_q, v2_q;
  logic [DCNT_W-1:0]     cnt_q;

  logic signed [SX_W-1:0]  sx_q, sy_q;
  logic signed [SXY_W-1:0] sxy_q;
  logic signed [PR_W-1:0]  prod_q;
  logic signed [SB-1:0]    a_s, b_s;
  logic [MAG_W-1:0]        mcand_q, macc_q;
  logic [SX_W-1:0]         mplier_q;
  logic signed [NUM_W-1:0] num_q;
  logic                    neg_q;
  logic [DVD_W-1:0]        qd_q;
  logic [D_W:0]            rem_q;

  logic             take_cmd, start_calc, k_last, i_last, j_last, mplier_zero, div_last;
  logic             sx_neg, sy_neg, sxy_neg, last_entry, emit_ok;
  logic [SX_W-1:0]  sx_mag, sy_mag;
  logic [SXY_W-1:0] sxy_mag;
  logic [NUM_W-1:0] num_mag;
  logic [NUM_W-1:0] p_ext;
  logic [D_W:0]     rem_sh, rem_nx;
  logic             ge;
  logic [EXW-1:0]   q_ext, lim, sat;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign take_cmd    = cmd_valid_i && cmd_ready_o;
  assign start_calc  = take_cmd && cmd_ctrl_i.calc;
  assign ram_we_o    = take_cmd && cmd_ctrl_i.wr;
  assign ram_waddr_o = cmd_addr_i;
  assign ram_wdata_o = cmd_data_i;
  assign ram_raddr_a_o = {i_q[VW-1:0], k_q};
  assign ram_raddr_b_o = {j_q[VW-1:0], k_q};

  always_comb begin
    if (num_vars_i == '0) begin
      m_clamp = NUM_VARS_W'(1);
    end else if (int'(num_vars_i) > MAX_VARS) begin
      m_clamp = NUM_VARS_W'(MAX_VARS);
    end else begin
      m_clamp = num_vars_i;
    end
    if (num_samples_i < NUM_SAMPLES_W'(2)) begin
      n_clamp = LOGN'(2);
    end else if (CMPW'(num_samples_i) > CMPW'(MAX_OBS)) begin
      n_clamp = LOGN'(MAX_OBS);
    end else begin
      n_clamp = LOGN'(num_samples_i);
    end
  end

  always_comb begin
    a_s         = $signed(ram_rdata_a_i);
    b_s         = $signed(ram_rdata_b_i);
    k_last      = (LOGN'(k_q) == n_q - LOGN'(1));
    i_last      = ({1'b0, i_q} == m_q - NUM_VARS_W'(1));
    j_last      = ({1'b0, j_q} == m_q - NUM_VARS_W'(1));
    last_entry  = i_last && j_last;
    mplier_zero = (mplier_q == '0);
    div_last    = (cnt_q == DCNT_W'(DVD_W - 1));
    sx_neg      = sx_q[SX_W-1];
    sy_neg      = sy_q[SX_W-1];
    sxy_neg     = sxy_q[SXY_W-1];
    sx_mag      = sx_neg ? (~sx_q + SX_W'(1)) : sx_q;
    sy_mag      = sy_neg ? (~sy_q + SX_W'(1)) : sy_q;
    sxy_mag     = sxy_neg ? (~sxy_q + SXY_W'(1)) : sxy_q;
    num_mag     = num_q[NUM_W-1] ? (~num_q + NUM_W'(1)) : num_q;
    p_ext       = NUM_W'(macc_q);
    rem_sh      = {rem_q[D_W-1:0], qd_q[DVD_W-1]};
    ge          = (rem_sh >= {1'b0, d_q});
    rem_nx      = ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
    q_ext       = EXW'(qd_q);
    lim         = neg_q ? (EXW'(1) << (COV_W - 1)) : ((EXW'(1) << (COV_W - 1)) - EXW'(1));
    sat         = (q_ext > lim) ? lim : q_ext;
    emit_ok     = (state_q == S_EMIT) && !out_full_i;
  end

  assign out_push_o  = emit_ok;
  assign out_row_o   = i_q;
  assign out_col_o   = j_q;
  assign out_cov_o   = neg_q ? (~sat[COV_W-1:0] + COV_W'(1)) : sat[COV_W-1:0];
  assign out_final_o = last_entry;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_calc) state_d = S_ACC;
      S_ACC:   if (k_last) state_d = S_DRAIN;
      S_DRAIN: if (!v1_q && !v2_q) state_d = S_MUL1;
      S_MUL1:  if (mplier_zero) state_d = S_MUL2;
      S_MUL2:  if (mplier_zero) state_d = S_PREP;
      S_PREP:  state_d = S_DIV;
      S_DIV:   if (div_last) state_d = S_EMIT;
      S_EMIT: begin
        if (emit_ok) begin
          state_d = last_entry ? S_IDLE : S_ACC;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      m_q     <= NUM_VARS_W'(1);
      n_q     <= LOGN'(2);
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == S_ACC);
      v2_q    <= v1_q;
      case (state_q)
        S_IDLE: begin
          if (start_calc) begin
            m_q <= m_clamp;
            n_q <= n_clamp;
            i_q <= '0;
            j_q <= '0;
            k_q <= '0;
          end
        end
        S_ACC:  k_q <= k_q + OBS_W'(1);
        S_PREP: cnt_q <= '0;
        S_DIV:  cnt_q <= cnt_q + DCNT_W'(1);
        S_EMIT: begin
          if (emit_ok && !last_entry) begin
            k_q <= '0;
            if (j_last) begin
              j_q <= '0;
              i_q <= i_q + IDX_W'(1);
            end else begin
              j_q <= j_q + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    d_q    <= D_W'(n_q) * D_W'(n_q - LOGN'(1));
    prod_q <= a_s * b_s;
    if ((state_q == S_IDLE) || (state_q == S_EMIT)) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
    end else begin
      if (v1_q) begin
        sx_q <= sx_q + SX_W'(a_s);
        sy_q <= sy_q + SX_W'(b_s);
      end
      if (v2_q) begin
        sxy_q <= sxy_q + SXY_W'(prod_q);
      end
    end
    case (state_q)
      S_DRAIN: begin
        mcand_q  <= MAG_W'(sxy_mag);
        mplier_q <= SX_W'(n_q);
        macc_q   <= '0;
      end
      S_MUL1, S_MUL2: begin
        if (mplier_zero) begin
          mcand_q  <= MAG_W'(sx_mag);
          mplier_q <= sy_mag;
          macc_q   <= '0;
          if (state_q == S_MUL1) begin
            num_q <= sxy_neg ? -$signed(p_ext) : $signed(p_ext);
          end else begin
            num_q <= (sx_neg ^ sy_neg) ? num_q + $signed(p_ext) : num_q - $signed(p_ext);
          end
        end else begin
          if (mplier_q[0]) begin
            macc_q <= macc_q + mcand_q;
          end
          mcand_q  <= {mcand_q[MAG_W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[SX_W-1:1]};
        end
      end
      S_PREP: begin
        neg_q <= num_q[NUM_W-1];
        qd_q  <= {num_mag[MAG_W-1:0], FRAC_BITS'(0)};
        rem_q <= '0;
      end
      S_DIV: begin
        rem_q <= rem_nx;
        qd_q  <= {qd_q[DVD_W-2:0], ge};
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (LOGN'(k_q) < n_q))
    else $error("sample index ran past the observation count");

  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push_o && out_final_o) |=> (state_q == S_IDLE))
    else $error("final entry did not end the matrix");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (d_q >= D_W'(2)))
    else $error("divisor below two");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL1) |-> (!v1_q && !v2_q))
    else $error("multiply started before sums settled");
`endif

endmodule

/* rtl/covariance_matrix.sv */
// Sample covariance matrix engine. Samples arrive as queue beats on push/full,
// one beat per sample with its variable and observation index; each is stored
// in the sample ram at the edge that takes it from the command queue.
// A beat with load_done set stores its sample, then starts the matrix: all
// num_vars x num_vars entries leave on the result side (empty/pop) in row
// order, final_entry marking the last one. Upper and lower halves agree.
// Each entry runs a sum pass over the n = num_samples observations, the
// multiplies n*Sxy and Sx*Sy, then a bit-serial divide of a dividend of
// DVD = 2*SAMPLE_BITS + 2*ceil(log2(MAX_OBS+1)) + 8 bits (58 at the defaults);
// the sum pass reads two samples a cycle from the two read ports of the sample ram.
// While the matrix is computed, further beats fill the two-entry command
// queue and then full is raised. When the receiver stalls, the two-entry
// result queue fills and the computation waits.
// Reset empties both queues and sets num_vars to 1 and num_samples to 2; the
// sample ram is not cleared and holds unknown data until written.
// Configuration goes through the apb port: num_vars at 0x0, num_samples at 0x4.
module covariance_matrix import cov_pkg::*; #(
  parameter int MAX_VARS    = MAX_VARS_DEF,
  parameter int MAX_OBS     = MAX_OBS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  logic [IDX_W-1:0]      var_index_i,
  input  logic [OBS_IN_W-1:0]   obs_index_i,
  input  logic [SAMPLE_W-1:0]   sample_value_i,
  input  logic                  load_done_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [IDX_W-1:0]      row_index_o,
  output logic [IDX_W-1:0]      col_index_o,
  output logic [COV_W-1:0]      cov_value_o,
  output logic                  final_entry_o
);

  localparam int AW    = var_w(MAX_VARS) + obs_w(MAX_OBS);
  localparam int OUT_W = 2 * IDX_W + COV_W + 1;

  logic [NUM_VARS_W-1:0]    num_vars_q;
  logic [NUM_SAMPLES_W-1:0] num_samples_q;
  logic                     cfg_wr;

  logic                   cmd_valid, cmd_ready;
  cmd_ctrl_t              cmd_ctrl;
  logic [AW-1:0]          cmd_addr;
  logic [SAMPLE_BITS-1:0] cmd_data;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

  logic               out_push, out_full, out_final;
  logic [IDX_W-1:0]   out_row, out_col;
  logic [COV_W-1:0]   out_cov;
  logic [OUT_W-1:0]   out_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_NUM_SAMPLES) ? APB_DATA_W'(num_samples_q)
                                                : APB_DATA_W'(num_vars_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q    <= NUM_VARS_W'(1);
      num_samples_q <= NUM_SAMPLES_W'(2);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NUM_VARS) begin
        num_vars_q <= pwdata[NUM_VARS_W-1:0];
      end else begin
        num_samples_q <= pwdata[NUM_SAMPLES_W-1:0];
      end
    end
  end

  cov_front #(
    .MAX_VARS    (MAX_VARS),
    .MAX_OBS     (MAX_OBS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .var_index_i    (var_index_i),
    .obs_index_i    (obs_index_i),
    .sample_value_i (sample_value_i),
    .load_done_i    (load_done_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_ctrl_o     (cmd_ctrl),
    .cmd_addr_o     (cmd_addr),
    .cmd_data_o     (cmd_data)
  );

  cov_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (1 << AW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  cov_back #(
    .MAX_VARS    (MAX_VARS),
    .MAX_OBS     (MAX_OBS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_ctrl_i    (cmd_ctrl),
    .cmd_addr_i    (cmd_addr),
    .cmd_data_i    (cmd_data),
    .num_vars_i    (num_vars_q),
    .num_samples_i (num_samples_q),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b),
    .ram_rdata_a_i (ram_rdata_a),
    .ram_rdata_b_i (ram_rdata_b),
    .out_push_o    (out_push),
    .out_full_i    (out_full),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .out_cov_o     (out_cov),
    .out_final_o   (out_final)
  );

  cov_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  ({out_row, out_col, out_cov, out_final}),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign {row_index_o, col_index_o, cov_value_o, final_entry_o} = out_data;

endmodule

/* tb/sv/covariance_matrix_tb.sv */
// self-checking testbench for the covariance matrix block: queue-driven stimulus, scoreboard
module covariance_matrix_tb import cov_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_W-1:0] ADDR_NUM_VARS    = APB_ADDR_W'(REG_NUM_VARS) << 2;
  localparam logic [APB_ADDR_W-1:0] ADDR_NUM_SAMPLES = APB_ADDR_W'(REG_NUM_SAMPLES) << 2;
  localparam int ITEM_TARGET = 380;

  typedef struct packed {
    logic [IDX_W-1:0]    var_idx;
    logic [OBS_IN_W-1:0] obs_idx;
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [COV_W-1:0] cov;
    logic             fin;
  } cov_entry_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  push = 1'b0;
  logic                  full;
  logic [IDX_W-1:0]      var_index_i = '0;
  logic [OBS_IN_W-1:0]   obs_index_i = '0;
  logic [SAMPLE_W-1:0]   sample_value_i = '0;
  logic                  load_done_i = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [IDX_W-1:0]      row_index_o, col_index_o;
  logic [COV_W-1:0]      cov_value_o;
  logic                  final_entry_o;

  covariance_matrix dut (.*);

  sample_beat_t beat_q[$];
  cov_entry_t   cov_q[$];
  shortint      sample_mem [MAX_VARS_DEF][MAX_OBS_DEF];
  bit           gen_written [MAX_VARS_DEF][MAX_OBS_DEF];
  logic [NUM_VARS_W-1:0]    cfg_vars = 4'd1;
  logic [NUM_SAMPLES_W-1:0] cfg_samples = 9'd2;
  int  tx_idle = 33, rx_idle = 66;
  bit  tx_hold = 1'b0, rx_hold = 1'b0;
  int  errors = 0;
  int  gen_count = 0;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int eff_vars(logic [NUM_VARS_W-1:0] v);
    return (v == 0) ? 1 : (v > MAX_VARS_DEF) ? MAX_VARS_DEF : int'(v);
  endfunction

  function automatic int eff_samples(logic [NUM_SAMPLES_W-1:0] v);
    return (v < 2) ? 2 : (v > MAX_OBS_DEF) ? MAX_OBS_DEF : int'(v);
  endfunction

  function automatic logic [COV_W-1:0] calc_cov(int r, int c, int n);
    longint sx, sy, sxy;
    logic signed [127:0] num, mag, quo, lim;
    bit neg;
    sx = 0; sy = 0; sxy = 0;
    for (int k = 0; k < n; k++) begin
      sx += sample_mem[r][k];
      sy += sample_mem[c][k];
      sxy += longint'(sample_mem[r][k]) * longint'(sample_mem[c][k]);
    end
    num = 128'(n) * 128'(sxy) - 128'(sx) * 128'(sy);
    neg = num < 0;
    mag = neg ? -num : num;
    quo = (mag <<< FRAC_BITS) / (128'(n) * 128'(n - 1));
    lim = neg ? (128'sd1 <<< (COV_W - 1)) : ((128'sd1 <<< (COV_W - 1)) - 1);
    if (quo > lim) quo = lim;
    return neg ? COV_W'(-quo) : COV_W'(quo);
  endfunction

  // predictor: runs on every accepted input beat
  always @(posedge clk_i) begin
    int m, n;
    cov_entry_t e;
    logic [COV_W-1:0] mat [MAX_VARS_DEF][MAX_VARS_DEF];
    if (rst_ni && push && !full) begin
      sample_mem[var_index_i][obs_index_i] = shortint'(sample_value_i);
      if (load_done_i) begin
        m = eff_vars(cfg_vars);
        n = eff_samples(cfg_samples);
        for (int i = 0; i < m; i++)
          for (int j = i; j < m; j++) begin
            mat[i][j] = calc_cov(i, j, n);
            mat[j][i] = mat[i][j];
          end
        for (int i = 0; i < m; i++)
          for (int j = 0; j < m; j++) begin
            e.row = IDX_W'(i);
            e.col = IDX_W'(j);
            e.cov = mat[i][j];
            e.fin = (i == m - 1) && (j == m - 1);
            cov_q.push_back(e);
          end
      end
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    sample_beat_t b;
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (beat_q.size() > 0 && !tx_hold && $urandom_range(99) >= tx_idle) begin
        b = beat_q.pop_front();
        push           <= 1'b1;
        var_index_i    <= b.var_idx;
        obs_index_i    <= b.obs_idx;
        sample_value_i <= b.sample;
        load_done_i    <= b.last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    cov_entry_t e;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (cov_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: row %0d col %0d cov %0h final %0b",
                     row_index_o, col_index_o, cov_value_o, final_entry_o);
        end else begin
          e = cov_q.pop_front();
          if (row_index_o !== e.row || col_index_o !== e.col ||
              cov_value_o !== e.cov || final_entry_o !== e.fin) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp row %0d col %0d cov %0h final %0b, got %0d %0d %0h %0b",
                       e.row, e.col, e.cov, e.fin,
                       row_index_o, col_index_o, cov_value_o, final_entry_o);
          end
        end
      end
      pop <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_NUM_VARS) cfg_vars = data[NUM_VARS_W-1:0];
    else cfg_samples = data[NUM_SAMPLES_W-1:0];
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    while (beat_q.size() > 0 || push || cov_q.size() > 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_beat(int v, int o, logic [SAMPLE_W-1:0] s, bit last);
    beat_q.push_back('{IDX_W'(v), OBS_IN_W'(o), s, last});
    gen_written[v][o] = 1'b1;
    gen_count++;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return SAMPLE_W'($urandom_range(15)) - 16'd8;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // one data set: full or partial rewrite in random order plus noise, last beat marked
  task automatic load_set(bit partial);
    int m, n, slots[$], pick, v, o;
    m = eff_vars(cfg_vars);
    n = eff_samples(cfg_samples);
    for (int i = 0; i < m * n; i++)
      if (!partial || !gen_written[i / n][i % n] || $urandom_range(2) == 0)
        slots.push_back(i);
    if (slots.size() == 0) slots.push_back($urandom_range(m * n - 1));
    slots.shuffle();
    while (slots.size() > 0) begin
      if ($urandom_range(9) == 0)
        add_beat($urandom_range(7), $urandom_range(255), rand_sample(), 1'b0);
      pick = slots.pop_front();
      v = pick / n;
      o = pick % n;
      add_beat(v, o, rand_sample(), slots.size() == 0);
    end
  endtask

  task automatic set_config(int nv, int ns);
    wait_quiet();
    apb_write(ADDR_NUM_VARS, APB_DATA_W'(nv));
    apb_write(ADDR_NUM_SAMPLES, APB_DATA_W'(ns));
  endtask

  initial begin
    @(posedge rst_ni);
    repeat (3) @(posedge clk_i);
    // directed: reset setting, extreme values
    add_beat(0, 0, 16'h8000, 1'b0);
    add_beat(0, 1, 16'h7fff, 1'b1);
    set_config(2, 1);
    add_beat(0, 0, 16'h8000, 1'b0);
    add_beat(0, 1, 16'h7fff, 1'b0);
    add_beat(1, 0, 16'h7fff, 1'b0);
    add_beat(1, 1, 16'h8000, 1'b1);
    add_beat(1, 1, 16'h0000, 1'b1);
    set_config(15, 0);
    load_set(1'b0);
    while (gen_count < ITEM_TARGET) begin
      if (gen_count > 2 * ITEM_TARGET / 3) begin
        tx_idle <= 0; rx_idle <= 0;
      end else if (gen_count > ITEM_TARGET / 3) begin
        tx_idle <= 66; rx_idle <= 33;
      end
      case ((gen_count < ITEM_TARGET / 6) ? 1 : $urandom_range(19))
        0: if (!gen_written[0][255] && gen_count < ITEM_TARGET / 3) begin
          set_config(0, 511);
          load_set(1'b0);
        end
        1: begin
          set_config($urandom_range(3, 8), $urandom_range(2, 5));
          wait_quiet();
          rx_hold <= 1'b1;
          fork
            begin
              repeat (400) @(posedge clk_i);
              rx_hold <= 1'b0;
            end
          join_none
          load_set(1'b0);
          load_set(1'b1);
          load_set(1'b1);
        end
        default: begin
          set_config($urandom_range(0, 3), $urandom_range(0, 9));
          load_set($urandom_range(1));
          if ($urandom_range(1)) load_set(1'b1);
        end
      endcase
    end
    wait_quiet();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && cov_q.size() == 0)
      $display("covariance_matrix regression: pass");
    else
      $display("covariance_matrix regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("covariance_matrix regression: fail");
    $finish;
  end

endmodule
